// ===== sv/hermite_transfer_function_defines.svh =====
// assertion macros shared by the hermite transfer function rtl
`ifndef HERMITE_TRANSFER_FUNCTION_DEFINES_SVH
`define HERMITE_TRANSFER_FUNCTION_DEFINES_SVH
`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define HTF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("htf assertion failed");
// plain condition checked at every clock edge outside reset
`define HTF_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("htf invariant failed");
`else
`define HTF_ASSERT(lbl, clk, rst_n, prop)
`define HTF_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/htf_pkg.sv =====
// shared types and constants of the hermite transfer function
package htf_pkg;
	localparam int HTF_MAX_POINTS = 16;
	localparam int ENTRY_W = 96;

	typedef enum logic [1:0] {
		CMD_EVAL   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EXISTS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_code_t;

	// controller states double as datapath operations
	typedef enum logic [3:0] {
		OP_IDLE, OP_DISPATCH, OP_RD, OP_CHK, OP_DIV, OP_MUL1, OP_MUL2, OP_BASIS,
		OP_SLOPE, OP_SUMS, OP_CHMUL, OP_CHACC, OP_SHRD, OP_SHWR, OP_COMMIT, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic is_eval;
		logic is_ins;
		logic is_nop;
		logic empty;
		logic chk_done;
		logic chk_bracket;
		logic chk_shift;
		logic div_last;
		logic sh_more;
		logic ch_last;
		logic out_free;
	} sts_t;
endpackage

// ===== sv/htf_ram.sv =====
// generic single write port ram with registered read
module htf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/htf_ctrl.sv =====
// controller state machine sequencing scan, divide, blend and table moves
module htf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  htf_pkg::sts_t sts,
	output htf_pkg::ctl_t ctl
);
	import htf_pkg::*;

	dp_op_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ctl.op  = state_q;
		case (state_q)
			OP_IDLE: begin
				if (sts.in_valid) state_d = OP_DISPATCH;
			end
			OP_DISPATCH: begin
				if (sts.is_nop || (sts.empty && !sts.is_ins)) state_d = OP_EMIT;
				else if (sts.empty) state_d = OP_SHRD;
				else state_d = OP_RD;
			end
			OP_RD: state_d = OP_CHK;
			OP_CHK: begin
				if (sts.chk_done) state_d = OP_EMIT;
				else if (sts.chk_bracket) state_d = OP_DIV;
				else if (sts.chk_shift) state_d = OP_SHRD;
				else state_d = OP_RD;
			end
			OP_DIV: begin
				if (sts.div_last) state_d = OP_MUL1;
			end
			OP_MUL1:  state_d = OP_MUL2;
			OP_MUL2:  state_d = OP_BASIS;
			OP_BASIS: state_d = OP_SLOPE;
			OP_SLOPE: state_d = OP_SUMS;
			OP_SUMS:  state_d = OP_CHMUL;
			OP_CHMUL: state_d = OP_CHACC;
			OP_CHACC: state_d = sts.ch_last ? OP_EMIT : OP_CHMUL;
			OP_SHRD:  state_d = sts.sh_more ? OP_SHWR : OP_COMMIT;
			OP_SHWR:  state_d = OP_SHRD;
			OP_COMMIT: state_d = OP_EMIT;
			OP_EMIT: begin
				if (sts.out_free) state_d = OP_IDLE;
			end
			default: state_d = OP_IDLE;
		endcase
	end
endmodule

// ===== sv/htf_datapath.sv =====
// point table, search, divider and hermite blend datapath
`include "hermite_transfer_function_defines.svh"
module htf_datapath #(
	parameter int MAX_POINTS = htf_pkg::HTF_MAX_POINTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  htf_pkg::ctl_t ctl,
	output htf_pkg::sts_t sts,
	input  logic          in_valid,
	input  logic [1:0]    in_cmd,
	input  logic [95:0]   in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [63:0]   out_data,
	output logic [1:0]    out_status
);
	import htf_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [1:0]         cmd_q;
	logic [15:0]        pos_q;
	logic [63:0]        col_in_q;
	logic [15:0]        slope_in_q;
	logic [CW-1:0]      count_q, idx_q, sh_q, key_q;
	logic               ent0_ok_q, rd0_q;
	logic [15:0]        pa_q, sa_q;
	logic [63:0]        ca_q, cb_q, res_q;
	logic [15:0]        sb_q;
	logic [1:0]         status_q;
	logic [15:0]        rem_q, dvs_q, u_q;
	logic [3:0]         bit_q;
	logic [1:0]         ch_q;
	logic [31:0]        u2_s;
	logic [47:0]        u3_s;
	logic signed [17:0] h00_q, h10_q, h01_q, h11_q;
	logic signed [33:0] m1_s, m2_s;
	logic signed [34:0] s_q, p1_s, p2_s;
	logic               out_valid_q;
	logic [63:0]        out_data_q;
	logic [1:0]         out_status_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata, ent;
	logic [15:0]        ep, es;
	logic [63:0]        ec;
	logic               is_eval, is_ins, is_rem, is_last, full, accept;
	logic               e_done, e_brk, i_eq, i_end, r_done;
	logic [16:0]        dtmp;
	logic               dge;
	logic signed [51:0] bu3, bu2, bu1, bone, brnd, h00w, h10w, h01w, h11w;
	logic signed [16:0] cav, cbv;
	logic signed [39:0] acc;
	logic [15:0]        chv;

	htf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// entry 0 reads as zero until first written
	assign ent = (rd0_q && !ent0_ok_q) ? '0 : rdata;
	assign ep  = ent[15:0];
	assign ec  = ent[79:16];
	assign es  = ent[95:80];

	assign is_eval = (cmd_q == CMD_EVAL);
	assign is_ins  = (cmd_q == CMD_INSERT);
	assign is_rem  = (cmd_q == CMD_REMOVE);
	assign is_last = (idx_q == CW'(count_q - CW'(1)));
	assign full    = (count_q >= CW'(MAX_POINTS));
	assign accept  = (ctl.op == OP_IDLE) && in_valid;

	// scan decisions on the entry just read
	assign e_done = ((idx_q == '0) && ((count_q == CW'(1)) || (pos_q < ep)))
	              || (is_last && (pos_q >= ep));
	assign e_brk  = (idx_q != '0) && (pos_q < ep);
	assign i_eq   = (ep == pos_q);
	assign i_end  = (ep > pos_q) || is_last;
	assign r_done = !i_eq && is_last;

	always_comb begin
		sts.in_valid    = in_valid;
		sts.is_eval     = is_eval;
		sts.is_ins      = is_ins;
		sts.is_nop      = (cmd_q == CMD_NOP);
		sts.empty       = (count_q == '0);
		sts.chk_done    = is_eval ? e_done : is_ins ? (i_eq || (i_end && full)) : r_done;
		sts.chk_bracket = is_eval && !e_done && e_brk;
		sts.chk_shift   = is_ins ? (!i_eq && i_end && !full) : (is_rem && i_eq);
		sts.div_last    = (bit_q == 4'd15);
		sts.sh_more     = is_ins ? (sh_q > key_q) : (CW'(sh_q + CW'(1)) < count_q);
		sts.ch_last     = (ch_q == 2'd3);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// table port addressing
	always_comb begin
		we    = 1'b0;
		waddr = sh_q[AW-1:0];
		wdata = ent;
		if (ctl.op == OP_SHRD) begin
			raddr = is_ins ? AW'(sh_q - CW'(1)) : AW'(sh_q + CW'(1));
		end else begin
			raddr = idx_q[AW-1:0];
		end
		if (ctl.op == OP_SHWR) begin
			we = 1'b1;
		end else if (ctl.op == OP_COMMIT && is_ins) begin
			we    = 1'b1;
			waddr = key_q[AW-1:0];
			wdata = {slope_in_q, col_in_q, pos_q};
		end
	end

	// divider step
	assign dtmp = {rem_q, 1'b0};
	assign dge  = (dtmp >= {1'b0, dvs_q});

	// hermite basis in q48 with rounding to q16
	always_comb begin
		bu3  = signed'({4'd0, u3_s});
		bu2  = signed'({4'd0, u2_s, 16'd0});
		bu1  = signed'({4'd0, u_q, 32'd0});
		bone = signed'({3'd0, 1'b1, 48'd0});
		brnd = signed'({20'd0, 1'b1, 31'd0});
		h00w = (bu3 <<< 1) - (bu2 + (bu2 <<< 1)) + bone + brnd;
		h10w = bu3 - (bu2 <<< 1) + bu1 + brnd;
		h01w = bu3 - bu2 + brnd;
		h11w = (bu2 + (bu2 <<< 1)) - (bu3 <<< 1) + brnd;
	end

	// channel blend and saturation
	assign cav = signed'({1'b0, ca_q[{ch_q, 4'd0} +: 16]});
	assign cbv = signed'({1'b0, cb_q[{ch_q, 4'd0} +: 16]});
	assign acc = signed'({{5{p1_s[34]}}, p1_s}) + signed'({{5{p2_s[34]}}, p2_s})
	           + signed'({s_q[34], s_q, 4'd0}) + signed'(40'd32768);
	always_comb begin
		if (acc[39]) chv = 16'd0;
		else if (|acc[38:32]) chv = 16'hffff;
		else chv = acc[31:16];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			ent0_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_EVAL;
			idx_q       <= '0;
			sh_q        <= '0;
			key_q       <= '0;
			bit_q       <= '0;
			ch_q        <= '0;
		end else begin
			if (we && waddr == '0) ent0_ok_q <= 1'b1;
			// result register: load on emit, clear on output transfer
			if (ctl.op == OP_EMIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (ctl.op)
				OP_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						idx_q <= '0;
						sh_q  <= count_q;
						key_q <= count_q;
					end
				end
				OP_CHK: begin
					if (is_eval) begin
						if (!e_done && e_brk) bit_q <= '0;
						else idx_q <= CW'(idx_q + CW'(1));
					end else if (is_ins) begin
						if (!i_eq && i_end) begin
							key_q <= (ep > pos_q) ? idx_q : count_q;
							sh_q  <= count_q;
						end else begin
							idx_q <= CW'(idx_q + CW'(1));
						end
					end else if (i_eq) begin
						key_q <= idx_q;
						sh_q  <= idx_q;
					end else begin
						idx_q <= CW'(idx_q + CW'(1));
					end
				end
				OP_DIV:   bit_q <= bit_q + 4'd1;
				OP_SUMS:  ch_q <= '0;
				OP_CHACC: ch_q <= ch_q + 2'd1;
				OP_SHWR:  sh_q <= is_ins ? CW'(sh_q - CW'(1)) : CW'(sh_q + CW'(1));
				OP_COMMIT: begin
					count_q <= is_ins ? CW'(count_q + CW'(1)) : CW'(count_q - CW'(1));
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd0_q <= (raddr == '0);
		case (ctl.op)
			OP_IDLE: begin
				if (accept) begin
					pos_q      <= in_data[15:0];
					col_in_q   <= in_data[79:16];
					slope_in_q <= in_data[95:80];
					res_q      <= '0;
					status_q   <= (in_cmd == CMD_REMOVE && count_q == '0) ? ST_NOTFOUND : ST_OK;
				end
			end
			OP_CHK: begin
				if (is_eval) begin
					if (e_done) begin
						res_q <= ec;
					end else if (e_brk) begin
						cb_q  <= ec;
						sb_q  <= es;
						rem_q <= pos_q - pa_q;
						dvs_q <= ep - pa_q;
						u_q   <= '0;
					end
					if (!e_brk) begin
						pa_q <= ep;
						ca_q <= ec;
						sa_q <= es;
					end
				end else if (is_ins) begin
					if (i_eq) status_q <= ST_EXISTS;
					else if (i_end && full) status_q <= ST_FULL;
				end else if (r_done) begin
					status_q <= ST_NOTFOUND;
				end
			end
			OP_DIV: begin
				rem_q <= dge ? 16'(dtmp - {1'b0, dvs_q}) : dtmp[15:0];
				u_q   <= {u_q[14:0], dge};
			end
			OP_MUL1: u2_s <= u_q * u_q;
			OP_MUL2: u3_s <= u2_s * u_q;
			OP_BASIS: begin
				h00_q <= h00w[49:32];
				h10_q <= h10w[49:32];
				h01_q <= h01w[49:32];
				h11_q <= h11w[49:32];
			end
			OP_SLOPE: begin
				m1_s <= h10_q * signed'(sa_q);
				m2_s <= h01_q * signed'(sb_q);
			end
			OP_SUMS: s_q <= signed'({m1_s[33], m1_s}) + signed'({m2_s[33], m2_s});
			OP_CHMUL: begin
				p1_s <= h00_q * cav;
				p2_s <= h11_q * cbv;
			end
			OP_CHACC: res_q[{ch_q, 4'd0} +: 16] <= chv;
			OP_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_data_q   <= res_q;
					out_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

	`HTF_ALWAYS(a_count_range, clk, arst_n, count_q <= CW'(MAX_POINTS))
	`HTF_ASSERT(a_ins_room, clk, arst_n, (ctl.op == OP_COMMIT && is_ins) |-> (!full))
	`HTF_ASSERT(a_shift_order, clk, arst_n, (ctl.op == OP_SHWR && is_ins) |-> (sh_q > key_q))
	`HTF_ASSERT(a_div_rem, clk, arst_n, (ctl.op == OP_DIV) |-> (rem_q < dvs_q))
endmodule

// ===== sv/hermite_transfer_function.sv =====
// top level of the hermite colour transfer function
// Colour transfer function over a sorted table of up to MAX_POINTS control points,
// one command at a time. An evaluate walks the table from the first point, reading
// each point from the table ram and checking it, then runs a restoring divider for the
// local fraction, followed by the basis terms and the per-channel blending; a sample
// outside the covered range skips the divider and blend. Insert and remove scan the
// same way, then move each displaced point with a ram read and a ram write. The
// input is taken only between commands; a finished result waits in an output
// register while the next command is accepted.
module hermite_transfer_function #(
	parameter int MAX_POINTS = htf_pkg::HTF_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // position, in_red, in_green, in_blue, in_alpha, in_slope
	input  logic [1:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic [1:0]  m_axis_tuser    // status
);
	import htf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	htf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .ctl(ctl)
	);

	htf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_valid(s_axis_tvalid), .in_cmd(s_axis_tuser), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_status(m_axis_tuser)
	);

	// input transfer only between commands
	assign s_axis_tready = (ctl.op == OP_IDLE);
endmodule
